/* src/bfern_pkg.sv */
// Shared types and constants for the fern point generator.
// No dependencies; imported by every module of the block.
package bfern_pkg;

    localparam int SCREEN_WIDTH_DEF  = 1024;
    localparam int SCREEN_HEIGHT_DEF = 768;
    localparam int FRAC_BITS_DEF     = 16;

    localparam int DRAW_W     = 16;
    localparam int PIX_W      = 16;
    localparam int ZOOM_W     = 16;
    localparam int SHIFT_W    = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [ZOOM_W-1:0] ZOOM_RESET = 16'd12800;

    // map code queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // draw thresholds for map selection
    localparam logic [DRAW_W-1:0] STEM_LIMIT = 16'd655;
    localparam logic [DRAW_W-1:0] MAIN_LIMIT = 16'd56361;
    localparam logic [DRAW_W-1:0] LEFT_LIMIT = 16'd60948;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ZOOM_SCALE = 2'd0,
        REG_SHIFT_X    = 2'd1,
        REG_SHIFT_Y    = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        MAP_STEM  = 2'd0,
        MAP_MAIN  = 2'd1,
        MAP_LEFT  = 2'd2,
        MAP_RIGHT = 2'd3
    } map_t;

    localparam int NUM_MAPS  = 4;
    localparam int NUM_COEFS = 5;

    // coefficient slots of one map row
    localparam int CO_A = 0;
    localparam int CO_B = 1;
    localparam int CO_C = 2;
    localparam int CO_D = 3;
    localparam int CO_F = 4;

    // per map: a, b, c, d, f in hundredths
    localparam int MAP_HUND [NUM_MAPS][NUM_COEFS] = '{
        '{  0,   0,  0, 16,   0},
        '{ 85,   4, -4, 85, 160},
        '{ 20, -26, 23, 22, 160},
        '{-15,  28, 26, 24,  44}
    };

    // queue head as seen by the back end
    typedef struct packed {
        logic valid;
        map_t map;
    } q_item_t;

    // hundredths to fixed point, rounded to nearest, ties away from zero
    function automatic longint q_coef(input int h, input int frac);
        longint mag;
        longint scaled;
        mag    = (h < 0) ? -longint'(h) : longint'(h);
        scaled = (mag * (longint'(1) << frac) + 50) / 100;
        return (h < 0) ? -scaled : scaled;
    endfunction

endpackage

/* src/bfern_front.sv */
// Front end: accepts draws, classifies each into a map code and queues it.
// Depends on bfern_pkg.
module bfern_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [bfern_pkg::DRAW_W-1:0]   s_random_draw,
    input  logic                           q_pop,
    output bfern_pkg::q_item_t             q_head
);
    import bfern_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    map_t             mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    map_t             draw_map;
    logic             push;
    logic             pop;

    always_comb begin
        if (s_random_draw < STEM_LIMIT) begin
            draw_map = MAP_STEM;
        end else if (s_random_draw < MAIN_LIMIT) begin
            draw_map = MAP_MAIN;
        end else if (s_random_draw < LEFT_LIMIT) begin
            draw_map = MAP_LEFT;
        end else begin
            draw_map = MAP_RIGHT;
        end
    end

    assign s_ready      = (cnt_reg != CNT_W'(QUEUE_DEPTH));
    assign push         = s_valid && s_ready;
    assign pop          = q_pop && (cnt_reg != '0);
    assign q_head.valid = (cnt_reg != '0);
    assign q_head.map   = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : rd_ptr_reg + 1'b1;
        end
        cnt_next = cnt_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= draw_map;
        end
    end

endmodule

/* src/bfern_back.sv */
// Back end: point recurrence (multiply, then round/offset/saturate) followed
// by the screen mapping pipeline and the output register. Depends on bfern_pkg.
module bfern_back #(
    parameter int SCREEN_WIDTH  = bfern_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = bfern_pkg::SCREEN_HEIGHT_DEF,
    parameter int FRAC_BITS     = bfern_pkg::FRAC_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  bfern_pkg::q_item_t                    q_head,
    output logic                                  q_pop,
    input  logic [bfern_pkg::ZOOM_W-1:0]          zoom_scale,
    input  logic signed [bfern_pkg::SHIFT_W-1:0]  shift_x,
    input  logic signed [bfern_pkg::SHIFT_W-1:0]  shift_y,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [bfern_pkg::PIX_W-1:0]    m_pixel_x,
    output logic signed [bfern_pkg::PIX_W-1:0]    m_pixel_y
);
    import bfern_pkg::*;

    localparam int PW   = FRAC_BITS + 6;        // point
    localparam int CW   = FRAC_BITS + 2;        // coefficient
    localparam int PRW  = PW + CW;              // map product
    localparam int ACCW = PRW + 1;              // product sum
    localparam int SHW  = ACCW - FRAC_BITS;     // sum after rounding shift
    localparam int OFW  = SHW + 1;              // after offset add
    localparam int SPW  = PW + ZOOM_W + 1;      // zoomed point
    localparam int UB   = FRAC_BITS + 8;        // screen fraction bits
    localparam int IW   = 20;                   // screen integer bits
    localparam int SUMW = UB + IW;
    localparam int CEN_X = SCREEN_WIDTH / 2;
    localparam int CEN_Y = SCREEN_HEIGHT / 2;

    localparam logic signed [ACCW-1:0] RND     = ACCW'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [IW-1:0]   PIX_MAX = IW'(32767);
    localparam logic signed [IW-1:0]   PIX_MIN = -IW'(32768);

    logic signed [CW-1:0] coef_tab [NUM_MAPS][NUM_COEFS];

    for (genvar gm = 0; gm < NUM_MAPS; gm++) begin : g_map
        for (genvar gk = 0; gk < NUM_COEFS; gk++) begin : g_coef
            assign coef_tab[gm][gk] = CW'(q_coef(MAP_HUND[gm][gk], FRAC_BITS));
        end
    end

    // point state
    logic signed [PW-1:0]  px_reg, px_next;
    logic signed [PW-1:0]  py_reg, py_next;
    // product stage
    logic                  a_vld_reg, a_vld_next;
    logic signed [PRW-1:0] pa_reg, pb_reg, pc_reg, pd_reg;
    logic signed [CW-1:0]  off_reg;
    // screen stages
    logic                  pnt_vld_reg, pnt_vld_next;
    logic                  c_vld_reg, c_vld_next;
    logic signed [SPW-1:0] sx_reg, sy_reg;
    logic                  m_valid_reg, m_valid_next;
    logic signed [PIX_W-1:0] pix_x_reg, pix_y_reg;

    logic a_fire, b_fire, c_fire, d_fire, c_free, out_free;

    logic signed [ACCW-1:0] acc_x, acc_y;
    logic signed [OFW-1:0]  sum_x, sum_y;
    logic signed [SUMW-1:0] scr_x, scr_y;

    function automatic logic signed [PW-1:0] sat_point(input logic signed [OFW-1:0] v);
        logic ovf;
        ovf = (v[OFW-1:PW-1] != {(OFW-PW+1){v[PW-1]}});
        if (!ovf) begin
            return v[PW-1:0];
        end else if (v[OFW-1]) begin
            return {1'b1, {(PW-1){1'b0}}};
        end else begin
            return {1'b0, {(PW-1){1'b1}}};
        end
    endfunction

    // truncate toward zero, saturate to pixel range
    function automatic logic signed [PIX_W-1:0] to_pix(input logic signed [SUMW-1:0] s);
        logic signed [IW-1:0] ip;
        ip = $signed(s[SUMW-1:UB]);
        if (s[SUMW-1] && (s[UB-1:0] != '0)) begin
            ip = ip + IW'(1);
        end
        if (ip > PIX_MAX) begin
            return PIX_W'(PIX_MAX);
        end else if (ip < PIX_MIN) begin
            return PIX_W'(PIX_MIN);
        end else begin
            return ip[PIX_W-1:0];
        end
    endfunction

    // handshake between stages, back to front
    assign out_free = !m_valid_reg || m_ready;
    assign d_fire   = c_vld_reg && out_free;
    assign c_free   = !c_vld_reg || d_fire;
    assign c_fire   = pnt_vld_reg && c_free;
    assign b_fire   = a_vld_reg && (!pnt_vld_reg || c_fire);
    // a new item reads the point only after the previous update has landed
    assign a_fire   = q_head.valid && !a_vld_reg;
    assign q_pop    = a_fire;

    always_comb begin
        acc_x = ACCW'(pa_reg) + ACCW'(pb_reg) + RND;
        acc_y = ACCW'(pc_reg) + ACCW'(pd_reg) + RND;
        sum_x = OFW'($signed(acc_x[ACCW-1:FRAC_BITS]));
        sum_y = OFW'($signed(acc_y[ACCW-1:FRAC_BITS])) + OFW'(off_reg);
        px_next = b_fire ? sat_point(sum_x) : px_reg;
        py_next = b_fire ? sat_point(sum_y) : py_reg;

        a_vld_next   = a_fire || (a_vld_reg && !b_fire);
        pnt_vld_next = b_fire || (pnt_vld_reg && !c_fire);
        c_vld_next   = c_fire || (c_vld_reg && !d_fire);
        m_valid_next = d_fire || (m_valid_reg && !m_ready);

        scr_x = ((SUMW'(CEN_X) + SUMW'(shift_x)) <<< UB) + SUMW'(sx_reg);
        scr_y = ((SUMW'(CEN_Y) + SUMW'(shift_y)) <<< UB) - SUMW'(sy_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            px_reg      <= '0;
            py_reg      <= '0;
            a_vld_reg   <= 1'b0;
            pnt_vld_reg <= 1'b0;
            c_vld_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            px_reg      <= px_next;
            py_reg      <= py_next;
            a_vld_reg   <= a_vld_next;
            pnt_vld_reg <= pnt_vld_next;
            c_vld_reg   <= c_vld_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_fire) begin
            pa_reg  <= PRW'(coef_tab[q_head.map][CO_A]) * PRW'(px_reg);
            pb_reg  <= PRW'(coef_tab[q_head.map][CO_B]) * PRW'(py_reg);
            pc_reg  <= PRW'(coef_tab[q_head.map][CO_C]) * PRW'(px_reg);
            pd_reg  <= PRW'(coef_tab[q_head.map][CO_D]) * PRW'(py_reg);
            off_reg <= coef_tab[q_head.map][CO_F];
        end
        if (c_fire) begin
            sx_reg <= SPW'(px_reg) * SPW'($signed({1'b0, zoom_scale}));
            sy_reg <= SPW'(py_reg) * SPW'($signed({1'b0, zoom_scale}));
        end
        if (d_fire) begin
            pix_x_reg <= to_pix(scr_x);
            pix_y_reg <= to_pix(scr_y);
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_pixel_x = pix_x_reg;
    assign m_pixel_y = pix_y_reg;

endmodule

/* src/barnsley_fern_point_generator_core.sv */
// Fern point generator: one draw in, one screen pixel out per item.
// An item passes the queue, multiply, update, zoom and output registers to m_valid; m_ready
// back-pressure can hold it in any of them. The recurrence loop (coefficient multiply, then
// round/offset/saturate into the point register) takes an item once the last update lands.
// Reset (aresetn low, synchronous): point to origin, queue empty, zoom 50.0, offsets 0.
// Depends on bfern_pkg, bfern_front, bfern_back.
module barnsley_fern_point_generator_core #(
    parameter int SCREEN_WIDTH  = bfern_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = bfern_pkg::SCREEN_HEIGHT_DEF,
    parameter int FRAC_BITS     = bfern_pkg::FRAC_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [bfern_pkg::DRAW_W-1:0]        s_random_draw,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [bfern_pkg::PIX_W-1:0]  m_pixel_x,
    output logic signed [bfern_pkg::PIX_W-1:0]  m_pixel_y,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bfern_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bfern_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import bfern_pkg::*;

    logic [ZOOM_W-1:0]         zoom_reg, zoom_next;
    logic signed [SHIFT_W-1:0] shift_x_reg, shift_x_next;
    logic signed [SHIFT_W-1:0] shift_y_reg, shift_y_next;
    q_item_t                   q_head;
    logic                      q_pop;

    assign cfg_ready = 1'b1;

    always_comb begin
        zoom_next    = zoom_reg;
        shift_x_next = shift_x_reg;
        shift_y_next = shift_y_reg;
        if (cfg_valid) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_ZOOM_SCALE: zoom_next    = cfg_data[ZOOM_W-1:0];
                REG_SHIFT_X:    shift_x_next = $signed(cfg_data[SHIFT_W-1:0]);
                REG_SHIFT_Y:    shift_y_next = $signed(cfg_data[SHIFT_W-1:0]);
                default: ;  // index beyond the list: ignored
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zoom_reg    <= ZOOM_RESET;
            shift_x_reg <= '0;
            shift_y_reg <= '0;
        end else begin
            zoom_reg    <= zoom_next;
            shift_x_reg <= shift_x_next;
            shift_y_reg <= shift_y_next;
        end
    end

    bfern_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_random_draw (s_random_draw),
        .q_pop         (q_pop),
        .q_head        (q_head)
    );

    bfern_back #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .FRAC_BITS     (FRAC_BITS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .zoom_scale (zoom_reg),
        .shift_x    (shift_x_reg),
        .shift_y    (shift_y_reg),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_pixel_x  (m_pixel_x),
        .m_pixel_y  (m_pixel_y)
    );

endmodule

/* tb/barnsley_fern_point_generator_core_tb.sv */
// Self-checking bench for barnsley_fern_point_generator_core: directed edge draws, then
// random draws under several zoom/offset settings, checked against a local fern predictor.
// Depends on bfern_pkg and the core RTL.
`timescale 1ns / 100ps

module barnsley_fern_point_generator_core_tb;

    import bfern_pkg::*;

    localparam int FB          = FRAC_BITS_DEF;
    localparam int PT_W        = FRAC_BITS_DEF + 6;
    localparam int DUT_LATENCY = 4;
    localparam int NUM_ROWS    = 20;
    localparam int RAND_PHASES = 6;

    // draw thresholds for the four maps
    localparam logic [DRAW_W-1:0] STEM_EDGE = 16'd655;
    localparam logic [DRAW_W-1:0] MAIN_EDGE = 16'd56361;
    localparam logic [DRAW_W-1:0] LEFT_EDGE = 16'd60948;

    // index past the register list, write must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    // a, b, c, d, f per map, in hundredths
    localparam int FERN_HUNDREDTHS [4][5] = '{
        '{  0,   0,  0, 16,   0},
        '{ 85,   4, -4, 85, 160},
        '{ 20, -26, 23, 22, 160},
        '{-15,  28, 26, 24,  44}
    };

    typedef struct {
        logic signed [PIX_W-1:0] x;
        logic signed [PIX_W-1:0] y;
    } pixel_t;

    typedef struct packed {
        logic [DRAW_W-1:0]       draw;
        logic                    known;
        logic signed [PIX_W-1:0] x;
        logic signed [PIX_W-1:0] y;
    } draw_row_t;

    logic                    aclk          = 1'b0;
    logic                    aresetn       = 1'b0;
    logic                    s_valid       = 1'b0;
    logic                    s_ready;
    logic [DRAW_W-1:0]       s_random_draw = '0;
    logic                    m_valid;
    logic                    m_ready       = 1'b0;
    logic signed [PIX_W-1:0] m_pixel_x;
    logic signed [PIX_W-1:0] m_pixel_y;
    logic                    cfg_valid     = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index     = '0;
    logic [CFG_DATA_W-1:0]   cfg_data      = '0;

    // travels with each item: typed-in expectation for the directed rows
    logic                    tag_known = 1'b0;
    logic signed [PIX_W-1:0] tag_x     = '0;
    logic signed [PIX_W-1:0] tag_y     = '0;

    logic calm = 1'b0;

    // predictor state and registers
    logic signed [PT_W-1:0]    fern_x   = '0;
    logic signed [PT_W-1:0]    fern_y   = '0;
    logic [ZOOM_W-1:0]         zoom_q88 = ZOOM_RESET;
    logic signed [SHIFT_W-1:0] off_x    = '0;
    logic signed [SHIFT_W-1:0] off_y    = '0;

    pixel_t pixel_q [$];

    int draws_sent  = 0;
    int pixels_seen = 0;
    int reg_writes  = 0;
    int settings    = 1;
    int mismatches  = 0;

    draw_row_t draw_rows [NUM_ROWS] = '{
        '{16'd0,     1'b1, 16'sd512, 16'sd384},
        '{16'd654,   1'b1, 16'sd512, 16'sd384},
        '{16'd655,   1'b0, 16'sd0,   16'sd0},
        '{16'd56360, 1'b0, 16'sd0,   16'sd0},
        '{16'd56361, 1'b0, 16'sd0,   16'sd0},
        '{16'd60947, 1'b0, 16'sd0,   16'sd0},
        '{16'd60948, 1'b0, 16'sd0,   16'sd0},
        '{16'd65535, 1'b0, 16'sd0,   16'sd0},
        '{16'd0,     1'b0, 16'sd0,   16'sd0},
        '{16'h5555,  1'b0, 16'sd0,   16'sd0},
        '{16'hAAAA,  1'b0, 16'sd0,   16'sd0},
        '{16'h00FF,  1'b0, 16'sd0,   16'sd0},
        '{16'hFF00,  1'b0, 16'sd0,   16'sd0},
        '{16'h7FFF,  1'b0, 16'sd0,   16'sd0},
        '{16'h8000,  1'b0, 16'sd0,   16'sd0},
        '{16'd1,     1'b0, 16'sd0,   16'sd0},
        '{16'd65534, 1'b0, 16'sd0,   16'sd0},
        '{16'd60000, 1'b0, 16'sd0,   16'sd0},
        '{16'd65000, 1'b0, 16'sd0,   16'sd0},
        '{16'd300,   1'b0, 16'sd0,   16'sd0}
    };

    barnsley_fern_point_generator_core i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_random_draw (s_random_draw),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel_x     (m_pixel_x),
        .m_pixel_y     (m_pixel_y),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #10 aclk = ~aclk;

    // ---------------- predictor ----------------

    function automatic longint hund_to_fix(input int h);
        longint mag;
        longint scaled;
        mag    = (h < 0) ? -longint'(h) : longint'(h);
        scaled = (mag * (longint'(1) << FB) + 50) / 100;
        return (h < 0) ? -scaled : scaled;
    endfunction

    function automatic longint fern_row(input longint p, input longint q, input longint cp,
                                        input longint cq, input longint off);
        longint acc;
        longint lim;
        lim = longint'(1) << (PT_W - 1);
        // full-precision sum, round half up, then offset and clamp
        acc = cp * p + cq * q + (longint'(1) << (FB - 1));
        acc = (acc >>> FB) + off;
        if (acc < -lim)
            acc = -lim;
        else if (acc > lim - 1)
            acc = lim - 1;
        return acc;
    endfunction

    function automatic logic signed [PIX_W-1:0] to_screen(input longint centre,
                                                         input longint scaled,
                                                         input longint shift);
        longint unit;
        longint pix;
        unit = longint'(1) << (FB + 8);
        pix  = (centre * unit + scaled + shift * unit) / unit;  // truncates toward zero
        if (pix < -32768)
            pix = -32768;
        else if (pix > 32767)
            pix = 32767;
        return pix[PIX_W-1:0];
    endfunction

    task automatic predict_pixel(input logic [DRAW_W-1:0] draw, input logic known,
                                 input logic signed [PIX_W-1:0] kx,
                                 input logic signed [PIX_W-1:0] ky);
        map_t   m;
        longint nx;
        longint ny;
        pixel_t p;
        if (draw < STEM_EDGE)
            m = MAP_STEM;
        else if (draw < MAIN_EDGE)
            m = MAP_MAIN;
        else if (draw < LEFT_EDGE)
            m = MAP_LEFT;
        else
            m = MAP_RIGHT;
        nx = fern_row(longint'(fern_x), longint'(fern_y), hund_to_fix(FERN_HUNDREDTHS[m][0]),
                      hund_to_fix(FERN_HUNDREDTHS[m][1]), 0);
        ny = fern_row(longint'(fern_x), longint'(fern_y), hund_to_fix(FERN_HUNDREDTHS[m][2]),
                      hund_to_fix(FERN_HUNDREDTHS[m][3]), hund_to_fix(FERN_HUNDREDTHS[m][4]));
        fern_x = nx[PT_W-1:0];
        fern_y = ny[PT_W-1:0];
        p.x = to_screen(SCREEN_WIDTH_DEF / 2, nx * longint'(zoom_q88), longint'(off_x));
        p.y = to_screen(SCREEN_HEIGHT_DEF / 2, -(ny * longint'(zoom_q88)), longint'(off_y));
        if (known) begin
            p.x = kx;
            p.y = ky;
        end
        pixel_q.push_back(p);
    endtask

    task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_ZOOM_SCALE: zoom_q88 = data[ZOOM_W-1:0];
            REG_SHIFT_X:    off_x    = data[SHIFT_W-1:0];
            REG_SHIFT_Y:    off_y    = data[SHIFT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic check_pixel(input logic signed [PIX_W-1:0] gx,
                               input logic signed [PIX_W-1:0] gy);
        pixel_t e;
        pixels_seen++;
        if (pixel_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("pixel %0d: unexpected item x=%0d y=%0d", pixels_seen, gx, gy);
        end else begin
            e = pixel_q.pop_front();
            if (gx !== e.x || gy !== e.y) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("pixel %0d: x exp %0d got %0d, y exp %0d got %0d",
                             pixels_seen, e.x, gx, e.y, gy);
            end
        end
    endtask

    // handshakes sampled on the edge; inputs change only in the NBA region
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready === 1'b1)
                apply_reg(cfg_index, cfg_data);
            if (s_valid && s_ready === 1'b1)
                predict_pixel(s_random_draw, tag_known, tag_x, tag_y);
            if (m_valid === 1'b1 && m_ready)
                check_pixel(m_pixel_x, m_pixel_y);
        end
    end

    always @(posedge aclk) begin
        m_ready <= calm || ($urandom_range(99) >= 34);
    end

    // ---------------- stimulus ----------------

    function automatic logic [DRAW_W-1:0] pick_draw();
        int r;
        logic [DRAW_W-1:0] edge_v;
        r = $urandom_range(99);
        if (r < 12) begin
            case ($urandom_range(2))
                0:       edge_v = STEM_EDGE;
                1:       edge_v = MAIN_EDGE;
                default: edge_v = LEFT_EDGE;
            endcase
            return edge_v + DRAW_W'($urandom_range(4)) - DRAW_W'(2);
        end
        if (r < 18)
            return DRAW_W'($urandom_range(654));
        return DRAW_W'($urandom);
    endfunction

    task automatic offer_draw(input logic [DRAW_W-1:0] d, input logic known,
                              input logic signed [PIX_W-1:0] ex,
                              input logic signed [PIX_W-1:0] ey);
        while (!calm && $urandom_range(99) < 34) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_random_draw <= d;
        tag_known     <= known;
        tag_x         <= ex;
        tag_y         <= ey;
        do
            @(posedge aclk);
        while (!(s_valid && s_ready === 1'b1));
        draws_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge aclk);
        while (!(cfg_valid && cfg_ready === 1'b1));
        reg_writes++;
    endtask

    task automatic drain_results();
        while (pixel_q.size() != 0)
            @(posedge aclk);
        repeat (DUT_LATENCY + 4) @(posedge aclk);
    endtask

    task automatic shuffle_regs();
        int start;
        cfg_reg_t which;
        start = $urandom_range(2);
        for (int k = 0; k < 3; k++) begin
            which = cfg_reg_t'((start + k) % 3);
            case (which)
                REG_ZOOM_SCALE: begin
                    case ($urandom_range(3))
                        0:       write_reg(which, $urandom_range(1) ? 16'hFFFF : 16'h0000);
                        1:       write_reg(which, CFG_DATA_W'($urandom_range(8000)));
                        default: write_reg(which, CFG_DATA_W'($urandom));
                    endcase
                end
                default: begin
                    // high nibble is don't-care, keep it random
                    case ($urandom_range(3))
                        0:       write_reg(which, {4'($urandom), 12'h800});
                        1:       write_reg(which, {4'($urandom), 12'h7FF});
                        default: write_reg(which, CFG_DATA_W'($urandom));
                    endcase
                end
            endcase
        end
        if ($urandom_range(2) == 0)
            write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
        cfg_valid <= 1'b0;
        settings++;
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (draw_rows[i])
            offer_draw(draw_rows[i].draw, draw_rows[i].known, draw_rows[i].x, draw_rows[i].y);
        s_valid <= 1'b0;
        drain_results();

        // zero zoom, offsets at opposite extremes
        write_reg(REG_ZOOM_SCALE, 16'h0000);
        write_reg(REG_SHIFT_X, 16'h0800);
        write_reg(REG_SHIFT_Y, 16'h07FF);
        cfg_valid <= 1'b0;
        settings++;
        repeat (40) offer_draw(pick_draw(), 1'b0, '0, '0);
        s_valid <= 1'b0;
        drain_results();

        // full zoom, offsets flipped, high data bits set, plus two dropped writes
        write_reg(REG_ZOOM_SCALE, 16'hFFFF);
        write_reg(REG_SHIFT_X, 16'hF7FF);
        write_reg(REG_SHIFT_Y, 16'hA800);
        write_reg(REG_UNUSED, 16'h0000);
        write_reg(REG_UNUSED, 16'hFFFF);
        cfg_valid <= 1'b0;
        settings++;
        repeat (40) offer_draw(pick_draw(), 1'b0, '0, '0);

        for (int p = 0; p < RAND_PHASES; p++) begin
            s_valid <= 1'b0;
            drain_results();
            shuffle_regs();
            calm <= (p == 2);
            repeat (100) offer_draw(pick_draw(), 1'b0, '0, '0);
        end
        s_valid <= 1'b0;
        calm    <= 1'b0;
        drain_results();

        $display("covered %0d draws (map edges, stem runs, random) and checked %0d pixels",
                 draws_sent, pixels_seen);
        $display("%0d register writes over %0d settings, zero/full zoom and offset limits",
                 reg_writes, settings);
        if (mismatches == 0 && pixel_q.size() == 0)
            $display("** barnsley_fern_point_generator_core: PASSED **");
        else
            $display("** barnsley_fern_point_generator_core: FAILED **");
        $finish;
    end

    initial begin
        #4_000_000;
        $display("timeout waiting for handshakes");
        $display("** barnsley_fern_point_generator_core: FAILED **");
        $finish;
    end

endmodule
